FILE: rtl/fmsr_pkg.sv
// shared types and constants of the feed motor stall reverse stepper
package fmsr_pkg;

    localparam int WINDOW = 10;
    localparam int PTR_W  = $clog2(WINDOW);
    localparam int CUR_W  = 16;
    localparam int POS_W  = 32;
    localparam int SUM_W  = CUR_W + $clog2(WINDOW);
    localparam int CMP_W  = SUM_W + CUR_W;
    localparam int CFG_W  = 15;
    localparam int THR_W  = 15;
    localparam int HOLD_W = 8;
    localparam int STEP_W = 10;
    localparam int BURST_W = 8;
    localparam int SHOT_W = BURST_W + 1;
    localparam int ADV_W  = SHOT_W + STEP_W;

    localparam logic [THR_W-1:0]  THR_RESET  = THR_W'(6000);
    localparam logic [HOLD_W-1:0] HOLD_RESET = HOLD_W'(25);
    localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(18);
    localparam logic [STEP_W-1:0] BACK_RESET = STEP_W'(9);

    typedef enum logic [1:0] {
        CFG_STALL_THRESHOLD,
        CFG_HOLD_TICKS,
        CFG_STEP_SIZE,
        CFG_BACK_OFF
    } cfg_index_t;

    typedef struct packed {
        logic signed [CUR_W-1:0] current_sample;
        logic signed [POS_W-1:0] motor_position;
        logic signed [POS_W-1:0] position_error;
        logic                    fire_level;
        logic [BURST_W-1:0]      burst_shots;
    } sample_t;

    typedef struct packed {
        logic signed [POS_W-1:0] target_position;
        logic                    target_written;
        logic                    reversing;
    } result_t;

    typedef struct packed {
        logic [THR_W-1:0]  stall_threshold;
        logic [HOLD_W-1:0] hold_ticks;
        logic [STEP_W-1:0] step_size;
        logic [STEP_W-1:0] back_off;
    } cfg_t;

    // front stage contents handed to the tracking stage
    typedef struct packed {
        logic                    valid;
        logic signed [CUR_W-1:0] current_sample;
        logic [POS_W-1:0]        motor_position;
        logic                    shot_ok;
        logic [ADV_W-1:0]        shot_adv;
    } front_t;

    typedef struct packed {
        logic              reverse;
        logic [HOLD_W-1:0] hold;
    } track_status_t;

endpackage

FILE: rtl/feed_motor_stall_reverse_stepper.sv
// top level of the feed motor stall reverse stepper
//
// one sample transfer per control tick on the sample channel (valid/stall),
// one result transfer per sample on the result channel (valid/stall)
// configuration writes go through cfg_valid/cfg_ready with cfg_index and
// cfg_data; cfg_ready is always high, write only while the block is idle
// a sample passes a register for the front stage and the window memory read,
// then a register for the tracking stage, before its result is offered
// throughput: one sample per cycle while the receiver does not stall; the
// window sum and set point update in a registered read-modify-write loop,
// and the window memory reads one entry and writes one entry in each cycle
// that samples move, at different addresses
// reset: window entries read as zero until written (one valid bit per entry),
// set point, window sum and reverse hold cleared, shot armed, registers back
// to their defaults; no clearing pass is needed
// receiver stall: the result register holds; the front stage then holds its
// sample and sample_stall rises until the result is taken, nothing is dropped
module feed_motor_stall_reverse_stepper (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 sample_valid,
    output logic                 sample_stall,
    input  fmsr_pkg::sample_t    sample,
    output logic                 result_valid,
    input  logic                 result_stall,
    output fmsr_pkg::result_t    result,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  fmsr_pkg::cfg_index_t cfg_index,
    input  logic [fmsr_pkg::CFG_W-1:0] cfg_data
);

    fmsr_pkg::cfg_t          cfg_reg;
    fmsr_pkg::front_t        front;
    fmsr_pkg::track_status_t trk_status;

    logic signed [fmsr_pkg::CUR_W-1:0] old_sample;
    logic accept;
    logic advance;

    // config registers, always ready
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.stall_threshold <= fmsr_pkg::THR_RESET;
            cfg_reg.hold_ticks      <= fmsr_pkg::HOLD_RESET;
            cfg_reg.step_size       <= fmsr_pkg::STEP_RESET;
            cfg_reg.back_off        <= fmsr_pkg::BACK_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                fmsr_pkg::CFG_STALL_THRESHOLD:
                    cfg_reg.stall_threshold <= cfg_data[fmsr_pkg::THR_W-1:0];
                fmsr_pkg::CFG_HOLD_TICKS:
                    cfg_reg.hold_ticks <= cfg_data[fmsr_pkg::HOLD_W-1:0];
                fmsr_pkg::CFG_STEP_SIZE:
                    cfg_reg.step_size <= cfg_data[fmsr_pkg::STEP_W-1:0];
                fmsr_pkg::CFG_BACK_OFF:
                    cfg_reg.back_off <= cfg_data[fmsr_pkg::STEP_W-1:0];
                default:
                    cfg_reg <= cfg_reg;
            endcase
        end
    end

    // front stage moves on when the result register is free or being drained
    assign advance      = front.valid && (!result_valid || !result_stall);
    assign sample_stall = front.valid && !advance;
    assign accept       = sample_valid && !sample_stall;

    // read oldest sample on transfer, overwrite it when the tick is processed
    fmsr_window_ram u_window (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rd_data (old_sample),
        .wr_en   (advance),
        .wr_data (front.current_sample)
    );

    fmsr_front_stage u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .advance   (advance),
        .sample    (sample),
        .step_size (cfg_reg.step_size),
        .front     (front)
    );

    fmsr_track_stage u_track (
        .clk          (clk),
        .rst_n        (rst_n),
        .advance      (advance),
        .front        (front),
        .old_sample   (old_sample),
        .cfg          (cfg_reg),
        .result_stall (result_stall),
        .result_valid (result_valid),
        .result       (result),
        .status       (trk_status)
    );

    // hold count is only nonzero during a reverse hold
    a_hold_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !trk_status.reverse |-> trk_status.hold == '0)
        else $error("hold counter nonzero outside reverse");

    // input stall only while a tick is waiting in the front stage
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        sample_stall |-> front.valid && result_valid && result_stall)
        else $error("sample stall without a blocked front stage");

    // a processed tick always lands in the result register
    a_tick_result: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> result_valid)
        else $error("processed tick produced no result");

    // reported reverse flag matches the tracking state after each tick
    a_rev_match: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> result.reversing == trk_status.reverse)
        else $error("result reverse flag out of step with state");

endmodule

FILE: rtl/fmsr_window_ram.sv
// circular current window memory with per-entry valid bits and registered read
module fmsr_window_ram (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           rd_en,
    output logic signed [fmsr_pkg::CUR_W-1:0] rd_data,
    input  logic                           wr_en,
    input  logic signed [fmsr_pkg::CUR_W-1:0] wr_data
);

    logic signed [fmsr_pkg::CUR_W-1:0] mem [fmsr_pkg::WINDOW];
    logic [fmsr_pkg::WINDOW-1:0]       valid_reg;
    logic [fmsr_pkg::PTR_W-1:0]        rd_ptr_reg;
    logic [fmsr_pkg::PTR_W-1:0]        wr_ptr_reg;
    logic signed [fmsr_pkg::CUR_W-1:0] rd_word_reg;
    logic                              rd_hit_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
        if (rd_en)
        begin
            rd_word_reg <= mem[rd_ptr_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            rd_hit_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_ptr_reg] <= 1'b1;
                if (wr_ptr_reg == fmsr_pkg::PTR_W'(fmsr_pkg::WINDOW - 1))
                    wr_ptr_reg <= '0;
                else
                    wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (rd_en)
            begin
                rd_hit_reg <= valid_reg[rd_ptr_reg];
                if (rd_ptr_reg == fmsr_pkg::PTR_W'(fmsr_pkg::WINDOW - 1))
                    rd_ptr_reg <= '0;
                else
                    rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    // never written entries read as zero
    assign rd_data = rd_hit_reg ? rd_word_reg : '0;

endmodule

FILE: rtl/fmsr_front_stage.sv
// front stage: fire edge detection, shot advance and error gate
module fmsr_front_stage (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          accept,
    input  logic                          advance,
    input  fmsr_pkg::sample_t             sample,
    input  logic [fmsr_pkg::STEP_W-1:0]   step_size,
    output fmsr_pkg::front_t              front
);

    fmsr_pkg::front_t front_reg;
    logic             shot_armed_reg;

    logic [fmsr_pkg::SHOT_W-1:0] shots;
    logic [fmsr_pkg::POS_W-1:0]  err_mag;
    logic                        err_small;

    always_comb
    begin
        shots = fmsr_pkg::SHOT_W'(sample.burst_shots)
              + fmsr_pkg::SHOT_W'(sample.fire_level & shot_armed_reg);
        err_mag = sample.position_error[fmsr_pkg::POS_W-1]
                ? -sample.position_error : sample.position_error;
        err_small = err_mag < fmsr_pkg::POS_W'(step_size);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg      <= '0;
            shot_armed_reg <= 1'b1;
        end
        else
        begin
            if (accept)
            begin
                front_reg.valid          <= 1'b1;
                front_reg.current_sample <= sample.current_sample;
                front_reg.motor_position <= sample.motor_position;
                front_reg.shot_ok        <= (shots != '0) && err_small;
                front_reg.shot_adv       <= fmsr_pkg::ADV_W'(shots)
                                          * fmsr_pkg::ADV_W'(step_size);
                shot_armed_reg           <= !sample.fire_level;
            end
            else if (advance)
            begin
                front_reg.valid <= 1'b0;
            end
        end
    end

    assign front = front_reg;

endmodule

FILE: rtl/fmsr_track_stage.sv
// tracking stage: window sum, stall test, reverse hold, set point and result register
module fmsr_track_stage (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              advance,
    input  fmsr_pkg::front_t                  front,
    input  logic signed [fmsr_pkg::CUR_W-1:0] old_sample,
    input  fmsr_pkg::cfg_t                    cfg,
    input  logic                              result_stall,
    output logic                              result_valid,
    output fmsr_pkg::result_t                 result,
    output fmsr_pkg::track_status_t           status
);

    logic signed [fmsr_pkg::SUM_W-1:0] sum_reg, sum_next;
    logic                              rev_reg, rev_next;
    logic [fmsr_pkg::HOLD_W-1:0]       hold_reg, hold_next;
    logic [fmsr_pkg::POS_W-1:0]        sp_reg, sp_next;
    logic                              written;
    logic                              valid_reg;
    fmsr_pkg::result_t                 result_reg;

    logic [fmsr_pkg::SUM_W-1:0] mag;
    logic [fmsr_pkg::CMP_W-1:0] limit;
    logic                       stall_hit;

    always_comb
    begin
        sum_next = sum_reg + fmsr_pkg::SUM_W'(front.current_sample)
                 - fmsr_pkg::SUM_W'(old_sample);
        mag = sum_next[fmsr_pkg::SUM_W-1] ? -sum_next : sum_next;
        limit = fmsr_pkg::CMP_W'(cfg.stall_threshold) * fmsr_pkg::CMP_W'(fmsr_pkg::WINDOW);
        stall_hit = fmsr_pkg::CMP_W'(mag) > limit;

        rev_next  = rev_reg;
        hold_next = hold_reg;
        sp_next   = sp_reg;
        written   = 1'b0;
        if (rev_reg)
        begin
            if (hold_reg < cfg.hold_ticks)
            begin
                hold_next = hold_reg + 1'b1;
            end
            else
            begin
                hold_next = '0;
                rev_next  = 1'b0;
                sp_next   = sp_reg + fmsr_pkg::POS_W'(cfg.back_off);
                written   = 1'b1;
            end
        end
        else if (stall_hit)
        begin
            sp_next   = front.motor_position - fmsr_pkg::POS_W'(cfg.back_off);
            rev_next  = 1'b1;
            hold_next = '0;
            written   = 1'b1;
        end
        // shots only once no reverse is running after the steps above
        if (front.shot_ok && !rev_next)
        begin
            sp_next = sp_next + fmsr_pkg::POS_W'(front.shot_adv);
            written = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg   <= '0;
            rev_reg   <= 1'b0;
            hold_reg  <= '0;
            sp_reg    <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                sum_reg   <= sum_next;
                rev_reg   <= rev_next;
                hold_reg  <= hold_next;
                sp_reg    <= sp_next;
                valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg.target_position <= sp_next;
            result_reg.target_written  <= written;
            result_reg.reversing       <= rev_next;
        end
    end

    assign result_valid   = valid_reg;
    assign result         = result_reg;
    assign status.reverse = rev_reg;
    assign status.hold    = hold_reg;

endmodule

FILE: dv/feed_motor_stall_reverse_stepper_tb.sv
// self-checking testbench of the feed motor stall reverse stepper
module feed_motor_stall_reverse_stepper_tb;
    import fmsr_pkg::*;

    // current waveform shapes the random stimulus moves between
    typedef enum int {
        REGIME_QUIET,
        REGIME_STALL_POS,
        REGIME_STALL_NEG,
        REGIME_NOISE
    } regime_t;

    localparam int RANDOM_PHASES   = 10;
    localparam int TICKS_PER_PHASE = 155;
    localparam int CALM_PHASE      = 3;    // no idling on either side in this phase
    localparam int IDLE_PCT        = 38;
    localparam int REPORT_LIMIT    = 10;
    localparam int HOLD_OFF_AT     = 850;  // accepted ticks before the long receiver hold-off
    localparam int HOLD_OFF_CYCLES = 200;
    localparam int SETTLE_CYCLES   = 4;    // lets the last result drain, with margin

    logic        clk = 1'b0;
    logic        rst_n;
    logic        sample_valid;
    logic        sample_stall;
    sample_t     sample;
    logic        result_valid;
    logic        result_stall;
    result_t     result;
    logic        cfg_valid;
    logic        cfg_ready;
    cfg_index_t  cfg_index;
    logic [CFG_W-1:0] cfg_data;

    // shadow of the block: window, set point tracking and register file
    logic signed [CUR_W-1:0] win_samples [WINDOW];
    longint                  win_sum;
    int                      win_ptr;
    logic                    rev_active;
    logic [HOLD_W-1:0]       hold_cnt;
    logic [POS_W-1:0]        set_pt;
    logic                    fire_armed;
    cfg_t                    regs;

    sample_t tick_q[$];      // ticks waiting to be offered, front is the one on the bus
    result_t target_q[$];    // set point results still owed by the block

    int      ticks_accepted;
    int      results_seen;
    int      fail_count;
    bit      sample_taken;
    bit      calm;
    bit      hold_off;

    regime_t regime;
    int      regime_left;
    logic    fire_lvl;

    feed_motor_stall_reverse_stepper dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #10 clk = ~clk;

    function automatic void log_failure(string msg);
        if (fail_count < REPORT_LIMIT)
            $display("%s", msg);
        fail_count++;
    endfunction

    // one control tick of the feed stepper: window update, stall/reverse, shots
    function automatic result_t feed_tick(sample_t s);
        longint  mag;
        longint  err_mag;
        int      shots;
        logic    wr;
        result_t r;
        wr    = 1'b0;
        shots = 0;

        // sliding window, oldest entry replaced
        win_sum = win_sum + longint'(s.current_sample) - longint'(win_samples[win_ptr]);
        win_samples[win_ptr] = s.current_sample;
        win_ptr = (win_ptr == WINDOW - 1) ? 0 : win_ptr + 1;

        if (rev_active)
        begin
            // count out the hold, then step forward by the back-off
            if (hold_cnt < regs.hold_ticks)
                hold_cnt = hold_cnt + 1'b1;
            else
            begin
                hold_cnt   = '0;
                rev_active = 1'b0;
                set_pt     = set_pt + POS_W'(regs.back_off);
                wr         = 1'b1;
            end
        end
        else
        begin
            // mean above threshold, compared without division
            mag = (win_sum < 0) ? -win_sum : win_sum;
            if (mag > longint'(regs.stall_threshold) * WINDOW)
            begin
                set_pt     = s.motor_position - POS_W'(regs.back_off);
                rev_active = 1'b1;
                hold_cnt   = '0;
                wr         = 1'b1;
            end
        end

        // rising fire edge counts one shot even if it is then blocked
        if (s.fire_level)
        begin
            if (fire_armed)
            begin
                fire_armed = 1'b0;
                shots      = 1;
            end
        end
        else
            fire_armed = 1'b1;
        shots = shots + int'(s.burst_shots);

        err_mag = longint'(s.position_error);
        if (err_mag < 0)
            err_mag = -err_mag;
        if (shots > 0 && !rev_active && err_mag < longint'(regs.step_size))
        begin
            set_pt = set_pt + POS_W'(shots * int'(regs.step_size));
            wr     = 1'b1;
        end

        r.target_position = set_pt;
        r.target_written  = wr;
        r.reversing       = rev_active;
        return r;
    endfunction

    function automatic void queue_tick(int cur, logic [POS_W-1:0] pos, logic [POS_W-1:0] err,
                                       logic fire, int burst);
        sample_t t;
        t.current_sample = cur[CUR_W-1:0];
        t.motor_position = pos;
        t.position_error = err;
        t.fire_level     = fire;
        t.burst_shots    = burst[BURST_W-1:0];
        tick_q.push_back(t);
    endfunction

    // random tick: current follows quiet, stalled or noisy stretches, error mostly
    // small enough to let shots through, fire toggles to make edges
    function automatic void queue_random_tick();
        int pick;
        int cur;
        int mag;
        int burst;
        logic [POS_W-1:0] pos;
        logic [POS_W-1:0] err;

        if (regime_left == 0)
        begin
            pick = $urandom_range(99);
            if (pick < 50)
                regime = REGIME_QUIET;
            else if (pick < 70)
                regime = REGIME_STALL_POS;
            else if (pick < 85)
                regime = REGIME_STALL_NEG;
            else
                regime = REGIME_NOISE;
            regime_left = $urandom_range(3, 40);
        end
        regime_left--;

        case (regime)
            REGIME_QUIET:
                cur = int'($urandom_range(4000)) - 2000;
            REGIME_STALL_POS:
                cur = ($urandom_range(99) < 30) ? 32767 : int'($urandom_range(15000, 32767));
            REGIME_STALL_NEG:
                cur = ($urandom_range(99) < 30) ? -32768 : -int'($urandom_range(15000, 32768));
            default:
                cur = int'($urandom());
        endcase

        case ($urandom_range(9))
            0: pos = 32'h7FFF_FFF0 + $urandom_range(15);
            1: pos = 32'h8000_0000 + $urandom_range(15);
            default: pos = $urandom();
        endcase

        case ($urandom_range(9))
            6: err = 32'h8000_0000;
            7: err = 32'h7FFF_FFFF;
            8, 9: err = $urandom();
            default:
            begin
                mag = $urandom_range(0, int'(regs.step_size) + 1);
                err = ($urandom_range(1) == 1) ? -mag : mag;
            end
        endcase

        if ($urandom_range(99) < 30)
            fire_lvl = ~fire_lvl;

        pick = $urandom_range(99);
        if (pick < 75)
            burst = 0;
        else if (pick < 90)
            burst = $urandom_range(1, 3);
        else if (pick < 95)
            burst = 255;
        else
            burst = $urandom_range(255);

        queue_tick(cur, pos, err, fire_lvl, burst);
    endfunction

    // mostly in-range values, sometimes an end of the range
    function automatic int pick_reg(int top, int lo, int hi);
        case ($urandom_range(5))
            0: return 0;
            1: return top;
            default: return $urandom_range(lo, hi);
        endcase
    endfunction

    // register write transfer, shadow updated when it lands
    task automatic write_reg(cfg_index_t idx, int value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_W'(value);
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_STALL_THRESHOLD: regs.stall_threshold = THR_W'(value);
            CFG_HOLD_TICKS:      regs.hold_ticks      = HOLD_W'(value);
            CFG_STEP_SIZE:       regs.step_size       = STEP_W'(value);
            CFG_BACK_OFF:        regs.back_off        = STEP_W'(value);
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_regs(int thr, int hold, int step, int back);
        write_reg(CFG_STALL_THRESHOLD, thr);
        write_reg(CFG_HOLD_TICKS, hold);
        write_reg(CFG_STEP_SIZE, step);
        write_reg(CFG_BACK_OFF, back);
        @(posedge clk);
    endtask

    // wait until every tick is in and every result is out, then let the pipe empty
    task automatic settle();
        while (tick_q.size() != 0 || target_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // driver, rising edge: a sample transfer feeds the shadow and retires the tick
    always @(posedge clk)
    begin
        if (rst_n && sample_valid && !sample_stall)
        begin
            target_q.push_back(feed_tick(sample));
            void'(tick_q.pop_front());
            ticks_accepted++;
            sample_taken = 1'b1;
        end
    end

    // driver, falling edge: an offered tick stays put until it is taken,
    // otherwise offer the next one or idle; the receiver stalls at random
    // and throughout the hold-off
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!sample_valid || sample_taken)
            begin
                sample_taken = 1'b0;
                if (tick_q.size() > 0 && (calm || $urandom_range(99) >= IDLE_PCT))
                begin
                    sample_valid <= 1'b1;
                    sample       <= tick_q[0];
                end
                else
                    sample_valid <= 1'b0;
            end
            result_stall <= hold_off || (!calm && $urandom_range(99) < IDLE_PCT);
        end
    end

    // monitor: each result transfer against the oldest owed result
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (target_q.size() == 0)
                log_failure($sformatf("result %0d: transfer with nothing owed, got %h",
                                      results_seen, result));
            else
            begin
                want = target_q.pop_front();
                if (result.target_position !== want.target_position ||
                    result.target_written !== want.target_written ||
                    result.reversing !== want.reversing)
                    log_failure($sformatf(
                        "result %0d: exp target %h written %b reversing %b, got %h %b %b",
                        results_seen, want.target_position, want.target_written,
                        want.reversing, result.target_position, result.target_written,
                        result.reversing));
            end
            results_seen++;
        end
    end

    // long receiver hold-off so the block backs up and stalls its input
    initial
    begin
        hold_off = 1'b0;
        wait (ticks_accepted >= HOLD_OFF_AT);
        @(negedge clk);
        hold_off = 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off = 1'b0;
    end

    initial
    begin
        #(64'd4_000_000);
        $display("feed_motor_stall_reverse_stepper_tb: FAIL");
        $finish;
    end

    initial
    begin
        int phase;
        rst_n        = 1'b0;
        sample_valid = 1'b0;
        sample       = '0;
        result_stall = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = CFG_STALL_THRESHOLD;
        cfg_data     = '0;

        for (int i = 0; i < WINDOW; i++)
            win_samples[i] = '0;
        win_sum    = 0;
        win_ptr    = 0;
        rev_active = 1'b0;
        hold_cnt   = '0;
        set_pt     = '0;
        fire_armed = 1'b1;
        regs       = '{THR_RESET, HOLD_RESET, STEP_RESET, BACK_RESET};

        regime         = REGIME_QUIET;
        regime_left    = 0;
        fire_lvl       = 1'b0;
        calm           = 1'b0;
        ticks_accepted = 0;
        results_seen   = 0;
        fail_count     = 0;
        sample_taken   = 1'b0;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset register values: edge shot, held fire, error just under and at
        // the step, burst lost to a large error, stall that also swallows an
        // edge and a burst, set point wrapping below the most negative position
        queue_tick(32767, 32'h0000_0000, 32'h0000_0000, 1'b1, 0);
        queue_tick(-32768, 32'h0000_0000, 32'h8000_0000, 1'b1, 255);
        queue_tick(0, 32'h7FFF_FFFF, 17, 1'b0, 1);
        queue_tick(0, 32'h0000_0000, -18, 1'b1, 0);
        queue_tick(0, 32'h0000_0000, 32'h0000_0000, 1'b1, 0);
        queue_tick(32767, 32'h8000_0000, 32'h0000_0000, 1'b0, 0);
        queue_tick(32767, 32'h8000_0005, 32'h0000_0000, 1'b1, 3);
        queue_tick(0, 32'h0000_0000, 32'h0000_0000, 1'b0, 2);
        settle();

        // zero threshold and zero hold: the running reverse ends at once and
        // takes shots on that tick, any nonzero mean stalls, large back-off wraps
        set_regs(0, 0, 1023, 1023);
        queue_tick(0, 32'h0000_0000, 5, 1'b1, 1);
        queue_tick(0, 32'h0000_0000, 32'h0000_0000, 1'b0, 0);
        queue_tick(0, 32'h0000_0000, 32'h7FFF_FFFF, 1'b1, 0);
        settle();

        // zero step: shots never move the set point; threshold at its top
        set_regs(32767, 255, 0, 0);
        queue_tick(0, 32'h0000_0000, 32'h0000_0000, 1'b0, 5);
        queue_tick(-32768, 32'h7FFF_FFFF, 32'h0000_0000, 1'b1, 0);
        queue_tick(32767, 32'h0000_0000, 32'h0000_0000, 1'b1, 0);
        queue_tick(0, 32'h0000_0000, 32'h0000_0000, 1'b1, 255);
        settle();

        // random phases, registers rewritten only while the block is empty
        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            set_regs(pick_reg(32767, 1000, 15000), pick_reg(255, 1, 40),
                     pick_reg(1023, 1, 100), pick_reg(1023, 0, 1023));
            calm = (phase == CALM_PHASE);
            repeat (TICKS_PER_PHASE) queue_random_tick();
            settle();
            calm = 1'b0;
        end

        if (fail_count == 0)
            $display("feed_motor_stall_reverse_stepper_tb: PASS");
        else
            $display("feed_motor_stall_reverse_stepper_tb: FAIL");
        $finish;
    end

endmodule

FILE: files.f
rtl/fmsr_pkg.sv
rtl/fmsr_window_ram.sv
rtl/fmsr_front_stage.sv
rtl/fmsr_track_stage.sv
rtl/feed_motor_stall_reverse_stepper.sv
dv/feed_motor_stall_reverse_stepper_tb.sv
